FILE: src/mtx_pkg.sv
// ----------------------------------------------------------------------------
// mtx_pkg: shared types and constants of the metatile tilemap expander
// Command codes, configuration register indexes, field widths and the
// structs that travel between the sequencer, the output stage and the top.
// ----------------------------------------------------------------------------
package mtx_pkg;

    localparam int ADDR_W    = 15;   // video memory word address
    localparam int WORD_W    = 16;   // tilemap word
    localparam int COORD_W   = 8;    // map column, row and metatile code
    localparam int INDEX_W   = 10;   // table word index
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [CMD_W-1:0] CMD_WR_WORD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_FLAG = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EXPAND  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BASE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_FORCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_EN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT  = 3'd5;

    localparam logic [WORD_W-1:0] PRIO_BIT = 16'h2000;

    typedef struct packed {
        logic [ADDR_W-1:0]  lower_base;
        logic [ADDR_W-1:0]  upper_base;
        logic               lower_force;
        logic               upper_enable;
        logic [COORD_W-1:0] map_width;
        logic [COORD_W-1:0] map_height;
    } t_cfg;

    // Side information of one beat, aligned with the table read data.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              layer;     // 1 for the upper layer
        logic              last;
        logic              off_map;
        logic              word_ok;   // code of this layer lies inside the table
        logic              flag_ok;   // upper code lies inside the flag table
        logic              force_pr;  // lower layer forced priority
    } t_beat;

endpackage

FILE: src/mtx_ram.sv
// ----------------------------------------------------------------------------
// mtx_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; the read register holds
// while the read enable is low. A read of the entry being written returns
// the old contents.
// ----------------------------------------------------------------------------
module mtx_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wa,
    input  logic [WIDTH-1:0]         i_wd,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_ra,
    output logic [WIDTH-1:0]         o_rd
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            r_rd <= r_mem[i_ra];
        end
    end

    assign o_rd = r_rd;

endmodule

FILE: src/mtx_seq.sv
// ----------------------------------------------------------------------------
// mtx_seq: command intake and expansion sequencer
// Takes input beats, issues table writes, and steps through the quadrants of an
// expanded cell, one table read per cycle unless stalled, with its beat information.
// ----------------------------------------------------------------------------
module mtx_seq #(
    parameter int METATILE_CODES = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mtx_pkg::t_cfg                    i_cfg,
    input  logic                             i_adv,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [mtx_pkg::CMD_W-1:0]        i_command,
    input  logic [mtx_pkg::INDEX_W-1:0]      i_table_index,
    input  logic [mtx_pkg::COORD_W-1:0]      i_map_x,
    input  logic [mtx_pkg::COORD_W-1:0]      i_map_y,
    input  logic [mtx_pkg::COORD_W-1:0]      i_lower_code,
    input  logic [mtx_pkg::COORD_W-1:0]      i_upper_code,
    output logic                             o_word_we,
    output logic [$clog2(METATILE_CODES)+1:0] o_word_wa,
    output logic [$clog2(METATILE_CODES)+1:0] o_word_ra,
    output logic                             o_flag_we,
    output logic [$clog2(METATILE_CODES)-1:0] o_flag_wa,
    output logic [$clog2(METATILE_CODES)-1:0] o_flag_ra,
    output logic                             o_meta_valid,
    output mtx_pkg::t_beat                   o_meta
);
    import mtx_pkg::*;

    localparam int CODE_W = $clog2(METATILE_CODES);

    logic               r_busy;
    logic [2:0]         r_step;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [COORD_W-1:0] r_lcode;
    logic [COORD_W-1:0] r_ucode;
    logic               r_off;
    logic               r_meta_valid;
    t_beat              r_meta;

    logic               last_issue;
    logic               take;
    logic               accept;
    logic               is_expand;
    logic [COORD_W-1:0] cur_code;
    logic [11:0]        offset;
    logic [ADDR_W-1:0]  base;
    logic               word_idx_ok;
    logic               flag_idx_ok;

    assign last_issue = r_busy && ((r_step == 3'd7) || (r_step == 3'd3 && !i_cfg.upper_enable));
    assign take       = i_adv && (!r_busy || last_issue);
    assign accept     = i_in_valid && take;
    assign is_expand  = (i_command == CMD_EXPAND);
    assign o_in_stall = !take;

    // Table writes.
    assign word_idx_ok = ({1'b0, i_table_index} < 11'(METATILE_CODES * 4));
    assign flag_idx_ok = ({1'b0, i_table_index[COORD_W-1:0]} < 9'(METATILE_CODES));
    assign o_word_we   = accept && (i_command == CMD_WR_WORD) && word_idx_ok;
    assign o_word_wa   = i_table_index[CODE_W+1:0];
    assign o_flag_we   = accept && (i_command == CMD_WR_FLAG) && flag_idx_ok;
    assign o_flag_wa   = i_table_index[CODE_W-1:0];

    // Table reads for the current quadrant.
    assign cur_code  = r_step[2] ? r_ucode : r_lcode;
    assign o_word_ra = {cur_code[CODE_W-1:0], r_step[1:0]};
    assign o_flag_ra = r_ucode[CODE_W-1:0];

    // Four-screen offset: screen in bits 11:10, row in 9:5, column in 4:0.
    assign offset = {r_y[4], r_x[4], r_y[3:0], r_step[1], r_x[3:0], r_step[0]};
    assign base   = r_step[2] ? i_cfg.upper_base : i_cfg.lower_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_step       <= 3'd0;
            r_meta_valid <= 1'b0;
        end else if (i_adv) begin
            r_meta_valid <= r_busy;
            if (accept && is_expand) begin
                r_busy <= 1'b1;
                r_step <= 3'd0;
            end else if (last_issue) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                r_step <= 3'(r_step + 3'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_expand) begin
            r_x     <= i_map_x;
            r_y     <= i_map_y;
            r_lcode <= i_lower_code;
            r_ucode <= i_upper_code;
            r_off   <= (i_map_x >= i_cfg.map_width) || (i_map_y >= i_cfg.map_height);
        end
        if (i_adv && r_busy) begin
            r_meta.addr     <= ADDR_W'(base + {3'b000, offset});
            r_meta.layer    <= r_step[2];
            r_meta.last     <= last_issue;
            r_meta.off_map  <= r_off;
            r_meta.word_ok  <= ({1'b0, cur_code} < 9'(METATILE_CODES));
            r_meta.flag_ok  <= ({1'b0, r_ucode} < 9'(METATILE_CODES));
            r_meta.force_pr <= i_cfg.lower_force;
        end
    end

    assign o_meta_valid = r_meta_valid;
    assign o_meta       = r_meta;

    a_expand_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && is_expand |=> r_busy && r_step == 3'd0)
        else $error("expand beat did not start the sequencer at step zero");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_step) && $stable(r_busy) && $stable(r_meta_valid))
        else $error("sequencer moved while the pipeline was held");

    a_no_write_mid_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_word_we || o_flag_we) |-> (!r_busy || last_issue))
        else $error("table write while a cell still has reads to issue");

endmodule

FILE: src/mtx_out.sv
// ----------------------------------------------------------------------------
// mtx_out: word assembly and output register
// Combines table read data with the beat information, applies the priority
// bit and the off-map rule, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module mtx_out (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_meta_valid,
    input  mtx_pkg::t_beat             i_meta,
    input  logic [mtx_pkg::WORD_W-1:0] i_rd_word,
    input  logic                       i_rd_flag,
    output logic                       o_adv,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [mtx_pkg::ADDR_W-1:0] o_vram_address,
    output logic [mtx_pkg::WORD_W-1:0] o_tile_word,
    output logic                       o_upper_layer,
    output logic                       o_last
);
    import mtx_pkg::*;

    logic              r_valid;
    logic [ADDR_W-1:0] r_addr;
    logic [WORD_W-1:0] r_word;
    logic              r_layer;
    logic              r_last;

    logic              pr;
    logic [WORD_W-1:0] n_word;

    assign o_adv = !r_valid || !i_out_stall;

    always_comb begin
        pr = i_meta.layer ? (i_meta.flag_ok && i_rd_flag) : i_meta.force_pr;
        if (i_meta.off_map) begin
            n_word = '0;
        end else begin
            n_word = (i_meta.word_ok ? i_rd_word : '0) | (pr ? PRIO_BIT : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_meta_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_addr  <= i_meta.addr;
            r_word  <= n_word;
            r_layer <= i_meta.layer;
            r_last  <= i_meta.last;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_vram_address = r_addr;
    assign o_tile_word    = r_word;
    assign o_upper_layer  = r_layer;
    assign o_last         = r_last;

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_adv && i_meta_valid |=> r_valid)
        else $error("pending beat was dropped on its way to the output register");

endmodule

FILE: src/metatile_tilemap_expander.sv
// ----------------------------------------------------------------------------
// metatile_tilemap_expander: metatile to 64x64 four-screen tilemap expansion
// Holds a metatile table (four words per code) and a priority flag per code
// in two RAMs, and expands map cells into lower and upper layer tilemap
// words with their video memory addresses.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake                 | Beat contents
//   --------+-----------+---------------------------+-------------------------------
//   cfg     | in        | i_cfg_we                  | i_cfg_index, i_cfg_data
//   in      | in        | i_in_valid / o_in_stall   | command, table index/word, cell
//   out     | out       | o_out_valid / i_out_stall | vram_address, tile_word, layer, last
//
// A table or flag write gives no beat. An expand beat occupies the sequencer
// for one read per word, eight words (four with the upper layer off), since
// every word needs its own read of the single read port of the metatile word
// RAM. The next input beat is taken in the cycle of the last read, so expands
// follow each other without a gap. After its read is issued, a word passes
// through the RAM read register and then the output register.
// Reset clears the control state and sets the configuration registers to defaults
// only; the tables hold no defined contents until written, and there is no clearing pass.
// An output stall freezes the whole pipeline, RAM read registers included, and
// turns into an input stall until the output register empties.
// ----------------------------------------------------------------------------
module metatile_tilemap_expander #(
    parameter int METATILE_CODES = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [mtx_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mtx_pkg::ADDR_W-1:0]    i_cfg_data,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [mtx_pkg::CMD_W-1:0]     i_command,
    input  logic [mtx_pkg::INDEX_W-1:0]   i_table_index,
    input  logic [mtx_pkg::WORD_W-1:0]    i_table_word,
    input  logic                          i_priority_flag,
    input  logic [mtx_pkg::COORD_W-1:0]   i_map_x,
    input  logic [mtx_pkg::COORD_W-1:0]   i_map_y,
    input  logic [mtx_pkg::COORD_W-1:0]   i_lower_code,
    input  logic [mtx_pkg::COORD_W-1:0]   i_upper_code,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [mtx_pkg::ADDR_W-1:0]    o_vram_address,
    output logic [mtx_pkg::WORD_W-1:0]    o_tile_word,
    output logic                          o_upper_layer,
    output logic                          o_last
);
    import mtx_pkg::*;

    localparam int CODE_W = $clog2(METATILE_CODES);

    t_cfg               r_cfg;
    logic               adv;
    logic               word_we;
    logic [CODE_W+1:0]  word_wa;
    logic [CODE_W+1:0]  word_ra;
    logic               flag_we;
    logic [CODE_W-1:0]  flag_wa;
    logic [CODE_W-1:0]  flag_ra;
    logic [WORD_W-1:0]  rd_word;
    logic               rd_flag;
    logic               meta_valid;
    t_beat              meta;

    // Configuration registers. The user must write them only while the block is idle (not enforced).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lower_base   <= '0;
            r_cfg.upper_base   <= '0;
            r_cfg.lower_force  <= 1'b0;
            r_cfg.upper_enable <= 1'b1;
            r_cfg.map_width    <= 8'd32;
            r_cfg.map_height   <= 8'd32;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LOWER_BASE:  r_cfg.lower_base   <= i_cfg_data;
                CFG_UPPER_BASE:  r_cfg.upper_base   <= i_cfg_data;
                CFG_LOWER_FORCE: r_cfg.lower_force  <= i_cfg_data[0];
                CFG_UPPER_EN:    r_cfg.upper_enable <= i_cfg_data[0];
                CFG_MAP_WIDTH:   r_cfg.map_width    <= i_cfg_data[COORD_W-1:0];
                CFG_MAP_HEIGHT:  r_cfg.map_height   <= i_cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // The sequencer takes commands, drives the table writes and issues one
    // table read per word of an expanded cell.
    mtx_seq #(
        .METATILE_CODES (METATILE_CODES)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_adv         (adv),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_table_index (i_table_index),
        .i_map_x       (i_map_x),
        .i_map_y       (i_map_y),
        .i_lower_code  (i_lower_code),
        .i_upper_code  (i_upper_code),
        .o_word_we     (word_we),
        .o_word_wa     (word_wa),
        .o_word_ra     (word_ra),
        .o_flag_we     (flag_we),
        .o_flag_wa     (flag_wa),
        .o_flag_ra     (flag_ra),
        .o_meta_valid  (meta_valid),
        .o_meta        (meta)
    );

    // Metatile words, four per code, addressed as code and quadrant.
    mtx_ram #(
        .WIDTH (WORD_W),
        .DEPTH (METATILE_CODES * 4)
    ) u_word_ram (
        .i_clk (i_clk),
        .i_we  (word_we),
        .i_wa  (word_wa),
        .i_wd  (i_table_word),
        .i_re  (adv),
        .i_ra  (word_ra),
        .o_rd  (rd_word)
    );

    // Priority flags, one per code; only the upper layer reads them.
    mtx_ram #(
        .WIDTH (1),
        .DEPTH (METATILE_CODES)
    ) u_flag_ram (
        .i_clk (i_clk),
        .i_we  (flag_we),
        .i_wa  (flag_wa),
        .i_wd  (i_priority_flag),
        .i_re  (adv),
        .i_ra  (flag_ra),
        .o_rd  (rd_flag)
    );

    // The output stage builds the final word and paces the whole pipeline.
    mtx_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_meta_valid   (meta_valid),
        .i_meta         (meta),
        .i_rd_word      (rd_word),
        .i_rd_flag      (rd_flag),
        .o_adv          (adv),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_vram_address (o_vram_address),
        .o_tile_word    (o_tile_word),
        .o_upper_layer  (o_upper_layer),
        .o_last         (o_last)
    );

endmodule
